// File: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned BitCntW = 4;
	localparam int unsigned PhaseW = 2;
	localparam logic [ByteW-1:0] AckWaitLimitRst = 8'd250;
	localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

	typedef enum logic [2:0] {
		OP_IDLE     = 3'd0,
		OP_START    = 3'd1,
		OP_STOP     = 3'd2,
		OP_WRITE    = 3'd3,
		OP_WAIT_ACK = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	typedef enum logic [PhaseW-1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2,
		PH_3 = 2'd3
	} phase_t;

	typedef struct packed {
		op_t                cur_op;
		phase_t             phase;
		logic [BitCntW-1:0] bit_cnt;
		logic [ByteW-1:0]   shift;
		logic [ByteW-1:0]   poll_cnt;
		logic               scl;
		logic               sda;
		logic               ack_choice;
		logic               ack_fail;
		logic [ByteW-1:0]   last_read;
	} eng_state_t;

	typedef struct packed {
		logic             scl_level;
		logic             sda_level;
		logic             busy;
		logic             done;
		logic [ByteW-1:0] read_data;
		logic             ack_missing;
	} tick_res_t;

	localparam eng_state_t EngStateRst = '{
		cur_op:     OP_IDLE,
		phase:      PH_0,
		bit_cnt:    '0,
		shift:      '0,
		poll_cnt:   '0,
		scl:        1'b1,
		sda:        1'b1,
		ack_choice: 1'b0,
		ack_fail:   1'b0,
		last_read:  '0
	};

endpackage

// File: sv/i2cm_tick.sv
// Next-state and pin levels for one bus delay tick of the I2C master sequencer.
module i2cm_tick (
	input  i2cm_pkg::eng_state_t              st,
	input  logic [2:0]                        operation,
	input  logic [i2cm_pkg::ByteW-1:0]        write_data,
	input  logic                              ack_after_read,
	input  logic                              sda_sample,
	input  logic [i2cm_pkg::ByteW-1:0]        ack_wait_limit,
	output i2cm_pkg::eng_state_t              nxt_st,
	output i2cm_pkg::tick_res_t               res
);

	always_comb begin
		i2cm_pkg::eng_state_t s;
		logic done;
		logic scl_low_after;
		logic [i2cm_pkg::BitCntW-1:0] bits_inc;

		s = st;
		done = 1'b0;
		scl_low_after = 1'b0;

		// a new operation only starts from idle; otherwise the code is ignored
		if (s.cur_op == i2cm_pkg::OP_IDLE &&
				operation >= 3'(i2cm_pkg::OP_START) &&
				operation <= 3'(i2cm_pkg::OP_READ)) begin
			s.cur_op = i2cm_pkg::op_t'(operation);
			s.phase = i2cm_pkg::PH_0;
			s.bit_cnt = '0;
			s.poll_cnt = '0;
			if (s.cur_op == i2cm_pkg::OP_WRITE) begin
				s.shift = write_data;
			end
			if (s.cur_op == i2cm_pkg::OP_READ) begin
				s.shift = '0;
				s.ack_choice = ack_after_read;
			end
		end

		bits_inc = s.bit_cnt + 1'b1;

		case (s.cur_op)
			i2cm_pkg::OP_START: begin
				s.scl = 1'b1;
				if (s.phase == i2cm_pkg::PH_0) begin
					s.sda = 1'b1;
					s.phase = i2cm_pkg::PH_1;
				end else begin
					s.sda = 1'b0;
					scl_low_after = 1'b1;
					done = 1'b1;
				end
			end
			i2cm_pkg::OP_STOP: begin
				if (s.phase == i2cm_pkg::PH_0) begin
					s.scl = 1'b0;
					s.sda = 1'b0;
					s.phase = i2cm_pkg::PH_1;
				end else begin
					s.scl = 1'b1;
					s.sda = 1'b1;
					done = 1'b1;
				end
			end
			i2cm_pkg::OP_WRITE: begin
				s.sda = s.shift[i2cm_pkg::ByteW-1];
				if (s.phase == i2cm_pkg::PH_0) begin
					s.scl = 1'b0;
					s.phase = i2cm_pkg::PH_1;
				end else if (s.phase == i2cm_pkg::PH_1) begin
					s.scl = 1'b1;
					s.phase = i2cm_pkg::PH_2;
				end else begin
					s.scl = 1'b0;
					s.phase = i2cm_pkg::PH_0;
					s.shift = {s.shift[i2cm_pkg::ByteW-2:0], 1'b0};
					s.bit_cnt = bits_inc;
					if (bits_inc >= i2cm_pkg::BitsPerByte) begin
						done = 1'b1;
					end
				end
			end
			i2cm_pkg::OP_WAIT_ACK: begin
				if (s.phase == i2cm_pkg::PH_0) begin
					s.sda = 1'b1;
					s.phase = i2cm_pkg::PH_1;
				end else if (s.phase == i2cm_pkg::PH_1) begin
					s.scl = 1'b1;
					s.sda = 1'b1;
					if (!sda_sample) begin
						s.ack_fail = 1'b0;
						scl_low_after = 1'b1;
						done = 1'b1;
					end else if (s.poll_cnt >= ack_wait_limit) begin
						s.phase = i2cm_pkg::PH_2;
					end else begin
						s.poll_cnt = s.poll_cnt + 1'b1;
					end
				end else if (s.phase == i2cm_pkg::PH_2) begin
					// timeout: stop condition driven over phases PH_2 and PH_3
					s.scl = 1'b0;
					s.sda = 1'b0;
					s.phase = i2cm_pkg::PH_3;
				end else begin
					s.scl = 1'b1;
					s.sda = 1'b1;
					s.ack_fail = 1'b1;
					done = 1'b1;
				end
			end
			i2cm_pkg::OP_READ: begin
				if (s.bit_cnt < i2cm_pkg::BitsPerByte) begin
					s.sda = 1'b1;
					if (s.phase == i2cm_pkg::PH_0) begin
						s.scl = 1'b0;
						s.phase = i2cm_pkg::PH_1;
					end else begin
						s.scl = 1'b1;
						s.shift = {s.shift[i2cm_pkg::ByteW-2:0], sda_sample};
						s.phase = i2cm_pkg::PH_0;
						s.bit_cnt = bits_inc;
					end
				end else begin
					s.sda = ~s.ack_choice;
					if (s.phase == i2cm_pkg::PH_0) begin
						s.scl = 1'b0;
						s.phase = i2cm_pkg::PH_1;
					end else begin
						s.scl = 1'b1;
						s.last_read = s.shift;
						scl_low_after = 1'b1;
						done = 1'b1;
					end
				end
			end
			default: begin
				s.cur_op = i2cm_pkg::OP_IDLE;
			end
		endcase

		res.scl_level = s.scl;
		res.sda_level = s.sda;

		if (scl_low_after) begin
			s.scl = 1'b0;
		end
		if (done) begin
			s.cur_op = i2cm_pkg::OP_IDLE;
			s.phase = i2cm_pkg::PH_0;
			s.bit_cnt = '0;
			s.poll_cnt = '0;
		end

		res.busy = (s.cur_op != i2cm_pkg::OP_IDLE);
		res.done = done;
		res.read_data = s.last_read;
		res.ack_missing = s.ack_fail;
		nxt_st = s;
	end

endmodule

// File: sv/i2c_master_bit_engine.sv
// I2C master bit engine: tick sequencer state, config register and result register.
//
// Usage: every input item is one bus delay tick and carries the SDA level seen
// during that tick. While no operation runs, the item's operation code may start
// start, stop, write byte, wait ack or read byte; codes given while busy, and
// unused codes, only advance the tick. Each accepted item yields exactly one
// result item with the SCL/SDA levels to drive for that tick, busy/done status,
// the last byte read and the missing-ack flag.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the result is taken; the sequencer takes at most one phase step per item.
// The single output register is overwritten as it is taken, so in_ready holds
// while the result is consumed in the same cycle; if the receiver stalls,
// in_ready drops and the pending result holds until taken.
// Config: cfg_data sets the ack wait poll limit; always ready, write it only
// while no operation is in progress.
// Reset: sequencer idle, SCL and SDA released high, limit 250, read byte 0,
// no result pending.
module i2c_master_bit_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 operation,
	input  logic [i2cm_pkg::ByteW-1:0] write_data,
	input  logic                       ack_after_read,
	input  logic                       sda_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       scl_level,
	output logic                       sda_level,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [i2cm_pkg::ByteW-1:0] read_data,
	output logic                       ack_missing,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [i2cm_pkg::ByteW-1:0] cfg_data
);

	i2cm_pkg::eng_state_t st_q;
	i2cm_pkg::eng_state_t nxt_st;
	i2cm_pkg::tick_res_t  tick_res;
	i2cm_pkg::tick_res_t  res_q;
	logic [i2cm_pkg::ByteW-1:0] limit_q;
	logic out_valid_q;
	logic in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	i2cm_tick u_tick (
		.st             (st_q),
		.operation      (operation),
		.write_data     (write_data),
		.ack_after_read (ack_after_read),
		.sda_sample     (sda_sample),
		.ack_wait_limit (limit_q),
		.nxt_st         (nxt_st),
		.res            (tick_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= i2cm_pkg::EngStateRst;
			limit_q <= i2cm_pkg::AckWaitLimitRst;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (in_fire) begin
				st_q <= nxt_st;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= tick_res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = res_q.scl_level;
	assign sda_level = res_q.sda_level;
	assign busy_res = res_q.busy;
	assign done_res = res_q.done;
	assign read_data = res_q.read_data;
	assign ack_missing = res_q.ack_missing;

endmodule

// File: sv/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       scl_level,
	input logic                       sda_level,
	input logic                       busy_res,
	input logic                       done_res,
	input logic [i2cm_pkg::ByteW-1:0] read_data,
	input logic                       ack_missing
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl_level) &&
		$stable(sda_level) && $stable(busy_res) && $stable(done_res) &&
		$stable(read_data) && $stable(ack_missing))
		else $error("result changed while stalled");

	// a stalled result blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while result stalled");

	// every accepted item produces a result next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// a finishing tick leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with busy set");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.scl_level  (scl_level),
	.sda_level  (sda_level),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.read_data  (read_data),
	.ack_missing(ack_missing)
);
